// ===== rtl/core/set_assoc_lru_cache_model_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model
// Clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH

// same-cycle implication
`define SALC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("salc assertion failed");

// next-cycle implication
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("salc assertion failed");

`endif

// ===== rtl/core/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, types and helpers of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_IFETCH = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  hits_now;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } rsp_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] tag;
    logic [31:0] stamp;
  } line_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_UPDATE
  } ctl_state_e;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic scan;
    logic update;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/core/salc_if.sv =====
// ----------------------------------------------------------------------------
// salc_req_if / salc_rsp_if
// Valid/ready request and response channels of the cache model.
// ----------------------------------------------------------------------------
interface salc_req_if;
  logic          valid;
  logic          ready;
  salc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface salc_rsp_if;
  logic          valid;
  logic          ready;
  salc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/set_assoc_lru_cache_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Hit/miss/eviction model of a set-associative cache with LRU replacement.
// ----------------------------------------------------------------------------
//  channel   dir  payload                               handshake
//  req_i     in   cmd, address                          valid/ready
//  rsp_o     out  hits_now, missed, evicted, totals     valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i                 cfg_we_i, no stall
//
//  A load, store or modify reads the line RAM one way at a time from accept
//  until a tag matches or the last way in use is read, then writes the line
//  back; a hit in way k ends the walk there.
//  An instruction fetch skips the walk and writes no line back.
//  After reset the line RAM is cleared, one line a cycle, all
//  2**MAX_SET_BITS * MAX_WAYS lines (2048 by default); req_i is held off.
//  A held result stalls the write-back of the next request, not its accept.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  salc_req_if.sink                        req_i,
  salc_rsp_if.source                      rsp_o
);

  salc_pkg::ctl_cmd_t ctl_cmd;
  salc_pkg::dp_stat_t dp_stat;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  salc_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .req_data_i  (req_i.data),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_data_o  (rsp_o.data)
  );

endmodule

// ===== rtl/core/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: clearing pass, request accept, way walk and line update.
// ----------------------------------------------------------------------------
module salc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  salc_pkg::dp_stat_t  stat_i,
  output salc_pkg::ctl_cmd_t  cmd_o
);

  salc_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      salc_pkg::ST_CLEAR: begin
        if (stat_i.clear_last) state_d = salc_pkg::ST_IDLE;
      end
      salc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = salc_pkg::ST_WALK;
      end
      salc_pkg::ST_WALK: begin
        if (stat_i.scan_done) state_d = salc_pkg::ST_UPDATE;
      end
      salc_pkg::ST_UPDATE: begin
        if (stat_i.out_free) state_d = salc_pkg::ST_IDLE;
      end
      default: state_d = salc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      salc_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      salc_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      salc_pkg::ST_WALK: begin
        cmd_o.scan = 1'b1;
      end
      salc_pkg::ST_UPDATE: begin
        cmd_o.update = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/salc_datapath.sv =====
// ----------------------------------------------------------------------------
// salc_datapath
// Address split, line store, way walk with LRU victim search, counters and
// the result register.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_assert.svh"

module salc_datapath #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  salc_pkg::ctl_cmd_t              cmd_i,
  output salc_pkg::dp_stat_t              stat_o,
  input  salc_pkg::req_t                  req_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output salc_pkg::rsp_t                  out_data_o
);

  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_LINES = (2 ** MAX_SET_BITS) * MAX_WAYS;
  localparam int LINE_AW   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);

  function automatic logic [LINE_AW-1:0] line_addr(input logic [SET_W-1:0] s,
                                                   input logic [WAY_W-1:0] w);
    return LINE_AW'(32'(s) * MAX_WAYS + 32'(w));
  endfunction

  // configuration
  logic [3:0] set_bits_q, ways_cfg_q;
  logic [5:0] boff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 4'd0;
      ways_cfg_q <= 4'd1;
      boff_q     <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        salc_pkg::CFG_SET_INDEX_BITS:    set_bits_q <= cfg_data_i[3:0];
        salc_pkg::CFG_WAYS_IN_USE:       ways_cfg_q <= cfg_data_i[3:0];
        salc_pkg::CFG_BLOCK_OFFSET_BITS: boff_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // address split at accept
  logic [3:0]        sbits_eff;
  logic [WCNT_W-1:0] ways_eff;
  logic [63:0]       shifted;
  logic [63:0]       tag_in;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_in;

  always_comb begin
    sbits_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits_q;
    if (ways_cfg_q == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_cfg_q) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_cfg_q);
    end
    shifted  = req_data_i.address >> boff_q;
    tag_in   = shifted >> sbits_eff;
    set_mask = SET_W'((32'd1 << sbits_eff) - 32'd1);
    set_in   = shifted[SET_W-1:0] & set_mask;
  end

  // control state
  logic [LINE_AW-1:0] clr_q, clr_d;
  logic [WCNT_W-1:0]  rd_way_q, rd_way_d;
  logic               chk_vld_q, chk_vld_d;
  logic               hit_q, hit_d;
  logic               empty_found_q, empty_found_d;
  logic               victim_vld_q, victim_vld_d;
  logic               fetch_q, fetch_d;
  logic               out_vld_q, out_vld_d;
  logic [31:0]        time_q, time_d;
  logic [31:0]        hit_tot_q, hit_tot_d;
  logic [31:0]        miss_tot_q, miss_tot_d;
  logic [31:0]        evict_tot_q, evict_tot_d;

  // payload
  logic [63:0]        tag_q, tag_d;
  logic [SET_W-1:0]   set_q, set_d;
  logic               mod_q, mod_d;
  logic [WCNT_W-1:0]  ways_q, ways_d;
  logic [WAY_W-1:0]   chk_way_q, chk_way_d;
  logic [WAY_W-1:0]   hit_way_q, hit_way_d;
  logic [WAY_W-1:0]   empty_way_q, empty_way_d;
  logic [WAY_W-1:0]   victim_way_q, victim_way_d;
  logic [31:0]        victim_stamp_q, victim_stamp_d;
  salc_pkg::rsp_t     rsp_q, rsp_d;

  // line store
  salc_pkg::line_t    rd_line, wr_line;
  logic               ram_we;
  logic [LINE_AW-1:0] ram_waddr, ram_raddr;
  logic [WAY_W-1:0]   wr_way;

  salc_ram #(
    .WIDTH ($bits(salc_pkg::line_t)),
    .DEPTH (NUM_LINES),
    .AW    (LINE_AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_line),
    .raddr_i (ram_raddr),
    .rdata_o (rd_line)
  );

  logic match, last_way, scan_done;
  logic hit1, miss1, ev1;
  logic [31:0] hit_tot_1;

  assign match     = chk_vld_q && rd_line.vld && (rd_line.tag == tag_q);
  assign last_way  = (WCNT_W'(chk_way_q) == (ways_q - WCNT_W'(1)));
  assign scan_done = cmd_i.scan && (fetch_q || (chk_vld_q && (match || last_way)));

  assign hit1      = !fetch_q && hit_q;
  assign miss1     = !fetch_q && !hit_q;
  assign ev1       = miss1 && !empty_found_q;
  assign hit_tot_1 = hit1 ? salc_pkg::sat_inc(hit_tot_q) : hit_tot_q;
  assign wr_way    = hit_q ? hit_way_q : (empty_found_q ? empty_way_q : victim_way_q);

  always_comb begin
    ram_raddr = line_addr(set_q, rd_way_q[WAY_W-1:0]);
    wr_line   = '0;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    if (cmd_i.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd_i.update && !fetch_q) begin
      ram_we        = 1'b1;
      ram_waddr     = line_addr(set_q, wr_way);
      wr_line.vld   = 1'b1;
      wr_line.tag   = tag_q;
      wr_line.stamp = time_q;
    end
  end

  always_comb begin
    clr_d          = cmd_i.clr_wr ? clr_q + LINE_AW'(1) : clr_q;
    rd_way_d       = rd_way_q;
    chk_vld_d      = 1'b0;
    chk_way_d      = chk_way_q;
    hit_d          = hit_q;
    hit_way_d      = hit_way_q;
    empty_found_d  = empty_found_q;
    empty_way_d    = empty_way_q;
    victim_vld_d   = victim_vld_q;
    victim_way_d   = victim_way_q;
    victim_stamp_d = victim_stamp_q;
    fetch_d        = fetch_q;
    mod_d          = mod_q;
    tag_d          = tag_q;
    set_d          = set_q;
    ways_d         = ways_q;
    time_d         = time_q;
    hit_tot_d      = hit_tot_q;
    miss_tot_d     = miss_tot_q;
    evict_tot_d    = evict_tot_q;
    rsp_d          = rsp_q;
    out_vld_d      = out_vld_q && !out_ready_i;

    if (cmd_i.accept) begin
      fetch_d       = (req_data_i.cmd == salc_pkg::CMD_IFETCH);
      mod_d         = (req_data_i.cmd == salc_pkg::CMD_MODIFY);
      tag_d         = tag_in;
      set_d         = set_in;
      ways_d        = ways_eff;
      time_d        = salc_pkg::sat_inc(time_q);
      rd_way_d      = '0;
      hit_d         = 1'b0;
      empty_found_d = 1'b0;
      victim_vld_d  = 1'b0;
    end

    if (cmd_i.scan) begin
      if (rd_way_q < ways_q) begin
        rd_way_d  = rd_way_q + WCNT_W'(1);
        chk_vld_d = !scan_done;
        chk_way_d = rd_way_q[WAY_W-1:0];
      end
      if (chk_vld_q) begin
        if (match) begin
          hit_d     = 1'b1;
          hit_way_d = chk_way_q;
        end else if (!rd_line.vld) begin
          if (!empty_found_q) begin
            empty_found_d = 1'b1;
            empty_way_d   = chk_way_q;
          end
        end else if (!victim_vld_q || (rd_line.stamp < victim_stamp_q)) begin
          victim_vld_d   = 1'b1;
          victim_way_d   = chk_way_q;
          victim_stamp_d = rd_line.stamp;
        end
      end
    end

    if (cmd_i.update) begin
      hit_tot_d   = mod_q ? salc_pkg::sat_inc(hit_tot_1) : hit_tot_1;
      miss_tot_d  = miss1 ? salc_pkg::sat_inc(miss_tot_q) : miss_tot_q;
      evict_tot_d = ev1 ? salc_pkg::sat_inc(evict_tot_q) : evict_tot_q;
      rsp_d.hits_now        = {1'b0, hit1} + {1'b0, mod_q};
      rsp_d.missed          = miss1;
      rsp_d.evicted         = ev1;
      rsp_d.total_hits      = hit_tot_d;
      rsp_d.total_misses    = miss_tot_d;
      rsp_d.total_evictions = evict_tot_d;
      out_vld_d             = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= '0;
      rd_way_q      <= '0;
      chk_vld_q     <= 1'b0;
      hit_q         <= 1'b0;
      empty_found_q <= 1'b0;
      victim_vld_q  <= 1'b0;
      fetch_q       <= 1'b0;
      out_vld_q     <= 1'b0;
      time_q        <= '0;
      hit_tot_q     <= '0;
      miss_tot_q    <= '0;
      evict_tot_q   <= '0;
    end else begin
      clr_q         <= clr_d;
      rd_way_q      <= rd_way_d;
      chk_vld_q     <= chk_vld_d;
      hit_q         <= hit_d;
      empty_found_q <= empty_found_d;
      victim_vld_q  <= victim_vld_d;
      fetch_q       <= fetch_d;
      out_vld_q     <= out_vld_d;
      time_q        <= time_d;
      hit_tot_q     <= hit_tot_d;
      miss_tot_q    <= miss_tot_d;
      evict_tot_q   <= evict_tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q          <= tag_d;
    set_q          <= set_d;
    mod_q          <= mod_d;
    ways_q         <= ways_d;
    chk_way_q      <= chk_way_d;
    hit_way_q      <= hit_way_d;
    empty_way_q    <= empty_way_d;
    victim_way_q   <= victim_way_d;
    victim_stamp_q <= victim_stamp_d;
    rsp_q          <= rsp_d;
  end

  assign stat_o.clear_last = (clr_q == LINE_AW'(NUM_LINES - 1));
  assign stat_o.scan_done  = scan_done;
  assign stat_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = rsp_q;

  `SALC_ASSERT_NEXT(a_accept_clears_walk, cmd_i.accept, !hit_q && !empty_found_q && !victim_vld_q && (rd_way_q == '0))
  `SALC_ASSERT_IMPL(a_hit_way_in_range, hit_q, WCNT_W'(hit_way_q) < ways_q)
  `SALC_ASSERT_IMPL(a_evict_has_victim, cmd_i.update && !fetch_q && !hit_q && !empty_found_q, victim_vld_q)
  `SALC_ASSERT_NEXT(a_miss_total_monotone, cmd_i.update, miss_tot_q >= $past(miss_tot_q))

endmodule
